// ===== hdl/b64le_pkg.sv =====
// Shared types, constants and the Base64 alphabet lookup for the line-wrapped encoder.
`default_nettype none
package b64le_pkg;

  localparam int unsigned LC_W    = 7;   // line character counter width
  localparam int unsigned GRP_MAX = 6;   // four characters plus CR LF
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = 3;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='

  localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
  localparam logic [CNT_W-1:0] CNT_QUAD  = 3'd4;
  localparam logic [CNT_W-1:0] CNT_BREAK = 3'd6;

  // one encoded group handed from the encoder to the output serializer
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] chars;
    logic [CNT_W-1:0]        cnt;
    logic                    eot;
  } grp_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      ch = 8'h2B;  // '+'
    end else begin
      ch = 8'h2F;  // '/'
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/base64_line_wrapped_encoder_core.sv =====
// Top level of the streaming Base64 encoder with CR LF line wrapping.
//
// Input stream: one raw byte per item on in_tdata, in_tlast on the final
// byte of a message. Output stream: one ASCII character per item on
// out_tdata, out_tlast on the final character of the encoded message.
// Every third byte yields four characters, plus CR LF once the line holds
// LINE_WIDTH or more characters; a short tail is padded with '=' and ends
// without CR LF. State clears after the final byte.
// A group-completing or final byte shows its first character in the cycle
// after acceptance. Characters leave at one per cycle while out_tready is
// high, set by the single-character output port. Bytes that only fill the
// group are taken every cycle, also while characters are still draining.
// Reset (rst_n low, synchronous) empties the group and the output register.
// When the receiver stalls, the current character holds and in_tready falls
// only for a byte that would produce a new group of characters.
`default_nettype none
module base64_line_wrapped_encoder_core
  import b64le_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 76
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast   // end_of_text
);

  grp_t grp;
  logic grp_ld;
  logic grp_free;

  b64le_encoder #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .grp_free (grp_free),
    .grp_ld   (grp_ld),
    .grp_o    (grp)
  );

  b64le_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_ld    (grp_ld),
    .grp_i     (grp),
    .grp_free  (grp_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/b64le_encoder.sv =====
// Byte gathering, group encoding, padding and line-break decision.
`default_nettype none
module b64le_encoder
  import b64le_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 76
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       grp_free,
  output logic            grp_ld,
  output grp_t            grp_o
);

  logic [7:0]      pend0_r, pend0_nxt;
  logic [7:0]      pend1_r, pend1_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic [LC_W-1:0] lc_r, lc_nxt;
  logic [LC_W-1:0] lc_sum;
  logic            emits;
  logic            acc;

  // only items that finish a group or end the message need the serializer
  assign emits     = (fill_r >= 2'd2) || in_tlast;
  assign in_tready = grp_free || !emits;
  assign acc       = in_tvalid && in_tready;
  assign grp_ld    = acc && emits;
  assign lc_sum    = lc_r + LC_W'(4);

  always_comb begin
    pend0_nxt   = pend0_r;
    pend1_nxt   = pend1_r;
    fill_nxt    = fill_r;
    lc_nxt      = lc_r;
    grp_o.chars = '0;
    grp_o.cnt   = CNT_NONE;
    grp_o.eot   = in_tlast;
    if (fill_r >= 2'd2) begin
      grp_o.chars[0] = sextet_char(pend0_r[7:2]);
      grp_o.chars[1] = sextet_char({pend0_r[1:0], pend1_r[7:4]});
      grp_o.chars[2] = sextet_char({pend1_r[3:0], in_tdata[7:6]});
      grp_o.chars[3] = sextet_char(in_tdata[5:0]);
      grp_o.chars[4] = CH_CR;
      grp_o.chars[5] = CH_LF;
      lc_nxt         = lc_sum;
      if (lc_sum >= LC_W'(LINE_WIDTH)) begin
        grp_o.cnt = CNT_BREAK;
        lc_nxt    = '0;
      end else begin
        grp_o.cnt = CNT_QUAD;
      end
      fill_nxt  = 2'd0;
      pend0_nxt = '0;
      pend1_nxt = '0;
    end else begin
      if (fill_r[0]) begin
        pend1_nxt = in_tdata;
      end else begin
        pend0_nxt = in_tdata;
      end
      fill_nxt = fill_r + 2'd1;
      if (in_tlast) begin
        grp_o.cnt = CNT_QUAD;
        if (fill_r == 2'd0) begin
          grp_o.chars[0] = sextet_char(in_tdata[7:2]);
          grp_o.chars[1] = sextet_char({in_tdata[1:0], 4'b0000});
          grp_o.chars[2] = CH_PAD;
        end else begin
          grp_o.chars[0] = sextet_char(pend0_r[7:2]);
          grp_o.chars[1] = sextet_char({pend0_r[1:0], in_tdata[7:4]});
          grp_o.chars[2] = sextet_char({in_tdata[3:0], 2'b00});
        end
        grp_o.chars[3] = CH_PAD;
      end
    end
    if (in_tlast) begin
      pend0_nxt = '0;
      pend1_nxt = '0;
      fill_nxt  = 2'd0;
      lc_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r <= '0;
      pend1_r <= '0;
      fill_r  <= 2'd0;
      lc_r    <= '0;
    end else if (acc) begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
      fill_r  <= fill_nxt;
      lc_r    <= lc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/b64le_serializer.sv =====
// Group register that drains one character per ready cycle onto the output.
`default_nettype none
module b64le_serializer
  import b64le_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       grp_ld,
  input  wire grp_t       grp_i,
  output logic            grp_free,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  logic [GRP_MAX-1:0][7:0] chars_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    eot_r;
  logic                    on_final;
  logic                    take;

  assign out_tvalid = (cnt_r != CNT_NONE);
  assign on_final   = (idx_r == IDX_W'(cnt_r - CNT_W'(1)));
  assign take       = out_tvalid && out_tready;
  // a new group may land in the same cycle the last character leaves
  assign grp_free   = !out_tvalid || (take && on_final);
  assign out_tdata  = chars_r[idx_r];
  assign out_tlast  = eot_r && on_final;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (grp_ld) begin
      cnt_nxt = grp_i.cnt;
      idx_nxt = '0;
    end else if (take) begin
      if (on_final) begin
        cnt_nxt = CNT_NONE;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_NONE;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ld) begin
      chars_r <= grp_i.chars;
      eot_r   <= grp_i.eot;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (IDX_W'(idx_r) < cnt_r))
    else $error("character index past group end");

  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_NONE) || (cnt_r == CNT_QUAD) || (cnt_r == CNT_BREAK))
    else $error("illegal group size");

  a_ld_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp_ld |-> grp_free)
    else $error("group loaded over undelivered characters");

  a_ld_starts: assert property (@(posedge clk) disable iff (!rst_n)
    grp_ld |=> (cnt_r == $past(grp_i.cnt)) && (idx_r == '0))
    else $error("group load did not restart serializer");

endmodule
`default_nettype wire

// ===== tb/tb_base64_line_wrapped_encoder_core.sv =====
// Self-checking testbench for the line-wrapped Base64 encoder core.
`timescale 1ns / 100ps
module tb_base64_line_wrapped_encoder_core;
  import b64le_pkg::*;

  localparam int LINE_W      = 76;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } char_item_t;

  // typed_n < 0: expectation comes from the predictor
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int          typed_n;
    logic [47:0] typed;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // encoder state as predicted
  logic [7:0] grp_buf [2];
  logic [1:0] grp_fill;
  logic [6:0] line_cnt;

  char_item_t pred_chars [$];
  char_item_t exp_chars [$];
  char_item_t got_exp;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         errors = 0;
  int         cycles = 0;

  dir_row_t dir_rows [22] = '{
    '{8'h00, 1'b1, 4, "AA=="},
    '{8'hFF, 1'b1, 4, "/w=="},
    '{8'hFF, 1'b0, 0, ""},
    '{8'hFF, 1'b1, 4, "//8="},
    '{8'h00, 1'b0, 0, ""},
    '{8'h00, 1'b0, 0, ""},
    '{8'h00, 1'b0, 4, "AAAA"},
    '{8'hFF, 1'b0, 0, ""},
    '{8'hFF, 1'b0, 0, ""},
    '{8'hFF, 1'b1, 4, "////"},
    '{8'h4D, 1'b0, 0, ""},
    '{8'h61, 1'b0, 0, ""},
    '{8'h6E, 1'b0, 4, "TWFu"},
    '{8'h4D, 1'b0, 0, ""},
    '{8'h61, 1'b1, 4, "TWE="},
    '{8'h4D, 1'b1, 4, "TQ=="},
    '{8'hA5, 1'b0, -1, '0},
    '{8'h5A, 1'b0, -1, '0},
    '{8'h3C, 1'b0, -1, '0},
    '{8'h80, 1'b0, -1, '0},
    '{8'h01, 1'b1, -1, '0},
    '{8'h7F, 1'b1, -1, '0}
  };

  base64_line_wrapped_encoder_core #(
    .LINE_WIDTH(LINE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return B64_ALPHABET[8*(63-int'(v)) +: 8];
  endfunction

  function automatic void add_char(input logic [7:0] ch);
    char_item_t c;
    c.ch  = ch;
    c.eot = 1'b0;
    pred_chars = {pred_chars, c};
  endfunction

  function automatic void clear_state();
    grp_buf[0] = 8'h00;
    grp_buf[1] = 8'h00;
    grp_fill   = 2'd0;
    line_cnt   = 7'd0;
  endfunction

  // characters caused by one accepted byte, appended to pred_chars
  function automatic void encode_byte(input logic [7:0] d, input logic l);
    logic [7:0] b0;
    logic [7:0] b1;
    if (grp_fill >= 2'd2) begin
      b0 = grp_buf[0];
      b1 = grp_buf[1];
      add_char(b64_char(b0[7:2]));
      add_char(b64_char({b0[1:0], b1[7:4]}));
      add_char(b64_char({b1[3:0], d[7:6]}));
      add_char(b64_char(d[5:0]));
      line_cnt = line_cnt + 7'd4;
      if (line_cnt >= LINE_W) begin
        add_char(CH_CR);
        add_char(CH_LF);
        line_cnt = 7'd0;
      end
      grp_fill   = 2'd0;
      grp_buf[0] = 8'h00;
      grp_buf[1] = 8'h00;
    end else begin
      grp_buf[grp_fill[0]] = d;
      grp_fill = grp_fill + 2'd1;
      if (l) begin
        b0 = grp_buf[0];
        b1 = grp_buf[1];
        add_char(b64_char(b0[7:2]));
        if (grp_fill == 2'd1) begin
          add_char(b64_char({b0[1:0], 4'b0000}));
          add_char(CH_PAD);
        end else begin
          add_char(b64_char({b0[1:0], b1[7:4]}));
          add_char(b64_char({b1[3:0], 2'b00}));
        end
        add_char(CH_PAD);
      end
    end
    if (l) begin
      if (pred_chars.size() > 0) pred_chars[pred_chars.size()-1].eot = 1'b1;
      clear_state();
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l, input int typed_n,
                           input logic [47:0] typed);
    char_item_t c;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred_chars.delete();
    encode_byte(d, l);
    if (typed_n < 0) begin
      exp_chars = {exp_chars, pred_chars};
    end else begin
      for (int k = 0; k < typed_n; k++) begin
        c.ch  = typed[8*(typed_n-1-k) +: 8];
        c.eot = l && (k == typed_n - 1);
        exp_chars = {exp_chars, c};
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h eot %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        got_exp = exp_chars.pop_front();
        if (out_tdata !== got_exp.ch) begin
          $display("%0t: char mismatch: expected %h, actual %h", $time, got_exp.ch, out_tdata);
          errors++;
        end
        if (out_tlast !== got_exp.eot) begin
          $display("%0t: eot mismatch: expected %b, actual %b", $time, got_exp.eot, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d chars outstanding", $time, exp_chars.size());
      $display("FAIL base64_line_wrapped_encoder_core");
      $finish;
    end
  end

  initial begin
    int len;
    int rand_items;
    clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed_n, dir_rows[r].typed);
    end

    // first message breaks the line on its final group, second breaks mid-message;
    // the idling phase moves on every 29 bytes
    rand_items = 0;
    for (int msg = 0; msg < 2; msg++) begin
      len = (msg == 0) ? 57 : 58;
      for (int i = 0; i < len; i++) begin
        case (rand_items / 29)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 81; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 81; end
          default: begin idle_pct = 18; stall_pct = 18; end
        endcase
        send_byte(8'($urandom_range(255)), i == len - 1, -1, '0);
        rand_items++;
      end
    end
    in_tvalid <= 1'b0;
    stall_pct = 0;

    while (exp_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS base64_line_wrapped_encoder_core");
    end else begin
      $display("FAIL base64_line_wrapped_encoder_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/b64le_pkg.sv
hdl/b64le_encoder.sv
hdl/b64le_serializer.sv
hdl/base64_line_wrapped_encoder_core.sv
tb/tb_base64_line_wrapped_encoder_core.sv
